@@ src/asl_pkg.sv @@
package asl_pkg;

    // Default widths of the value path and of the tick counts.
    localparam int VALUE_BITS_DEF = 16;
    localparam int TICK_BITS_DEF  = 16;

    // Configuration register indexes, taken from paddr[2].
    localparam logic REG_RISE_TICKS = 1'b0;
    localparam logic REG_FALL_TICKS = 1'b1;

    // Width of the configuration address: two 32-bit registers at 0 and 4.
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

endpackage

@@ src/asl_step_div.sv @@
module asl_step_div #(
    parameter int VALUE_BITS = asl_pkg::VALUE_BITS_DEF,
    parameter int TICK_BITS  = asl_pkg::TICK_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TICK_BITS-1:0]  i_elapsed,
    input  logic [TICK_BITS-1:0]  i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quot
);
    import asl_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    // Computes (elapsed << (VALUE_BITS-1)) / divisor one quotient bit per cycle.
    // The caller only starts it when elapsed < 2*divisor, so the quotient fits
    // VALUE_BITS and the upper dividend bits (elapsed >> 1) are already below
    // the divisor and seed the partial remainder.
    logic [TICK_BITS-1:0]  r_rem;
    logic [TICK_BITS-1:0]  r_div;
    logic                  r_bit;
    logic [VALUE_BITS-1:0] r_quot;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_done;

    logic [TICK_BITS:0] n_shifted;
    logic [TICK_BITS:0] n_trial;

    assign n_shifted = {r_rem, r_bit};
    assign n_trial   = n_shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_BITS'(VALUE_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_elapsed[TICK_BITS-1:1]};
            r_bit  <= i_elapsed[0];
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= n_trial[TICK_BITS] ? n_shifted[TICK_BITS-1:0] : n_trial[TICK_BITS-1:0];
            r_bit  <= 1'b0;
            r_quot <= {r_quot[VALUE_BITS-2:0], ~n_trial[TICK_BITS]};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ src/asymmetric_slew_limiter_unit.sv @@
// An accepted item passes through ST_DIV and then ST_APPLY when the step needs the
// serial divider, one quotient bit per cycle, or goes straight to ST_APPLY when the
// selected time is zero or the step saturates; ST_APPLY registers the result once
// the output register is free. s_tready is low while an item is in work.
// Reset (synchronous, active low) clears both time registers and the held value to
// zero and empties the output register.
module asymmetric_slew_limiter_unit #(
    parameter int VALUE_BITS = asl_pkg::VALUE_BITS_DEF,
    parameter int TICK_BITS  = asl_pkg::TICK_BITS_DEF,
    parameter int IN_W       = ((VALUE_BITS + TICK_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input items
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: target_value (VALUE_BITS, signed), elapsed_ticks (TICK_BITS), zero pad
    input  logic [IN_W-1:0]                    i_s_tdata,
    // Result items
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: limited_value (VALUE_BITS, signed), zero pad
    output logic [OUT_W-1:0]                   o_m_tdata,
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [asl_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [asl_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [asl_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import asl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_APPLY = 3'b100
    } t_state;

    t_state                r_state;
    logic [TICK_BITS-1:0]  r_rise;
    logic [TICK_BITS-1:0]  r_fall;
    logic [VALUE_BITS-1:0] r_held;
    logic [VALUE_BITS-1:0] r_target;
    logic                  r_jump;
    logic                  r_sat;
    logic                  r_out_vld;

    logic                  cfg_wr;
    logic                  in_acc;
    logic [VALUE_BITS-1:0] in_target;
    logic [TICK_BITS-1:0]  in_elapsed;
    logic [TICK_BITS-1:0]  in_period;
    logic                  in_sat;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;

    logic signed [VALUE_BITS:0] n_diff;
    logic [VALUE_BITS:0]        n_dist;
    logic [VALUE_BITS-1:0]      n_step;
    logic [VALUE_BITS-1:0]      n_held;
    logic                       out_free;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise <= '0;
            r_fall <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_RISE_TICKS: r_rise <= pwdata[TICK_BITS-1:0];
                REG_FALL_TICKS: r_fall <= pwdata[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RISE_TICKS: prdata = CFG_DATA_BITS'(r_rise);
            REG_FALL_TICKS: prdata = CFG_DATA_BITS'(r_fall);
            default:        prdata = '0;
        endcase
    end

    // Input side: the fall time applies only when the target lies below the held value.
    assign in_target  = i_s_tdata[VALUE_BITS-1:0];
    assign in_elapsed = i_s_tdata[VALUE_BITS+TICK_BITS-1:VALUE_BITS];
    assign in_period  = ($signed(in_target) < $signed(r_held)) ? r_fall : r_rise;
    // The quotient reaches 2^VALUE_BITS exactly when elapsed >= 2*period.
    assign in_sat     = {1'b0, in_elapsed} >= {in_period, 1'b0};
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;

    asl_step_div #(
        .VALUE_BITS (VALUE_BITS),
        .TICK_BITS  (TICK_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc && (in_period != '0) && !in_sat),
        .i_elapsed (in_elapsed),
        .i_divisor (in_period),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // Move toward the target by the step, never past it.
    assign n_diff = $signed({r_target[VALUE_BITS-1], r_target})
                  - $signed({r_held[VALUE_BITS-1], r_held});
    assign n_dist = n_diff[VALUE_BITS] ? (VALUE_BITS+1)'(-n_diff) : n_diff;
    assign n_step = r_sat ? '1 : div_quot;

    always_comb begin
        if (r_jump || ({1'b0, n_step} >= n_dist)) begin
            n_held = r_target;
        end else if (n_diff[VALUE_BITS]) begin
            n_held = r_held - n_step;
        end else begin
            n_held = r_held + n_step;
        end
    end

    assign out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_held    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ((in_period == '0) || in_sat) ? ST_APPLY : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        r_held    <= n_held;
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_target <= in_target;
            r_jump   <= (in_period == '0);
            r_sat    <= in_sat;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_W'(r_held);

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after taking an item");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_held_stable_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> $stable(r_held))
        else $error("held value changed while a result was waiting");

endmodule
